// ===== src/urxf_pkg.sv =====
// Shared types and constants for the serial receiver with receive FIFO.
`timescale 1ns / 1ps

package urxf_pkg;

	// Field and register widths fixed by the interface.
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned FILL_W   = 6;
	localparam int unsigned BIT_W    = 3;

	// Bit period after reset, in line ticks (processed items).
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;

	// Index of the last data bit of a frame.
	localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

	// Receiver phases, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	// A completed byte offered to the FIFO.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
	} push_t;

	// FIFO results for the item being processed.
	typedef struct packed {
		logic              pop_valid;
		logic [DATA_W-1:0] pop_byte;
		logic [FILL_W-1:0] fill_count;
		logic              overflow;
	} fifo_status_t;

endpackage

// ===== src/uart_receiver_with_fifo.sv =====
// An item waits in the input register; its result is registered when the item is processed.
// One item per cycle while out_stall is low; input and result registers hold one item each.
// The FIFO head is prefetched by a registered memory read, so a pop is served from a register.
// Reset (arst_n low): receiver idle, FIFO empty, bit period 5000; storage is not cleared.
// No clearing pass follows reset; an item may be transferred as soon as arst_n is high.
`timescale 1ns / 1ps

module uart_receiver_with_fifo #(
	parameter int unsigned FIFO_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          line_level,
	input  logic                          pop_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pop_valid,
	output logic [urxf_pkg::DATA_W-1:0]   pop_byte,
	output logic [urxf_pkg::FILL_W-1:0]   fill_count,
	output logic                          overflow,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [urxf_pkg::PERIOD_W-1:0] cfg_data
);
	import urxf_pkg::*;

	logic                valid_s1, line_s1, pop_s1;
	logic                out_valid_s2;
	fifo_status_t        result_s2;
	logic [PERIOD_W-1:0] bit_period_q;
	logic                adv;
	push_t               push;
	fifo_status_t        status;

	// The held item is processed when the result register is free or being emptied.
	assign adv       = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	// Bit period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bit_period_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			line_s1 <= line_level;
			pop_s1  <= pop_req;
		end
	end

	// Frame sampler and FIFO.
	urxf_deser u_deser (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.line_level (line_s1),
		.bit_period (bit_period_q),
		.push       (push)
	);

	urxf_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.push    (push),
		.pop_req (pop_s1),
		.status  (status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= status;
		end
	end

	assign out_valid  = out_valid_s2;
	assign pop_valid  = result_s2.pop_valid;
	assign pop_byte   = result_s2.pop_byte;
	assign fill_count = result_s2.fill_count;
	assign overflow   = result_s2.overflow;

	// The input side is only held back while an item waits in the input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no item held");

	// A result without a popped byte carries a zero byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pop_valid) |-> (pop_byte == '0))
		else $error("pop byte non-zero without pop");

	// An overflow is only flagged for a byte that has just completed.
	a_push_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && status.overflow) |-> push.valid)
		else $error("overflow flagged without a completed byte");

	// Processing an item always fills the result register on the next edge.
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed item produced no result");

endmodule

// ===== src/urxf_deser.sv =====
// Serial frame sampler: start check, eight data bits LSB first, stop bit.
`timescale 1ns / 1ps

module urxf_deser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       line_level,
	input  logic [urxf_pkg::PERIOD_W-1:0] bit_period,
	output urxf_pkg::push_t            push
);
	import urxf_pkg::*;

	phase_t              phase_q, phase_n;
	logic [PERIOD_W-1:0] tick_q, tick_n, tick_inc, target;
	logic [BIT_W-1:0]    bit_q, bit_n;
	logic [DATA_W-1:0]   shift_q, shift_n;
	logic                reached;

	// Tick counter and the target of the current phase.
	always_comb begin
		tick_inc = tick_q + PERIOD_W'(1);
		target   = (phase_q == PH_START) ? (bit_period >> 1) : bit_period;
		reached  = (tick_inc >= target);
	end

	// Next-state logic for one tick.
	always_comb begin
		phase_n    = phase_q;
		tick_n     = reached ? '0 : tick_inc;
		bit_n      = bit_q;
		shift_n    = shift_q;
		push.valid = 1'b0;
		push.data  = shift_q;
		case (phase_q)
			PH_IDLE: begin
				tick_n = '0;
				if (!line_level) begin
					phase_n = PH_START;
				end
			end
			PH_START: begin
				if (reached) begin
					if (line_level) begin
						phase_n = PH_IDLE;
					end else begin
						phase_n = PH_DATA;
						bit_n   = '0;
						shift_n = '0;
					end
				end
			end
			PH_DATA: begin
				if (reached) begin
					shift_n = shift_q | (DATA_W'(line_level) << bit_q);
					if (bit_q == LAST_BIT) begin
						bit_n   = '0;
						phase_n = PH_STOP;
					end else begin
						bit_n = bit_q + BIT_W'(1);
					end
				end
			end
			PH_STOP: begin
				if (reached) begin
					push.valid = 1'b1;
					phase_n    = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		endcase
	end

	// State registers advance once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
		end
	end

endmodule

// ===== src/urxf_fifo.sv =====
// Ring receive FIFO with one slot kept empty and a prefetched head entry.
`timescale 1ns / 1ps

module urxf_fifo #(
	parameter int unsigned FIFO_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  urxf_pkg::push_t        push,
	input  logic                   pop_req,
	output urxf_pkg::fifo_status_t status
);
	import urxf_pkg::*;

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

	logic [DATA_W-1:0] mem [FIFO_DEPTH];
	logic [DATA_W-1:0] head_q;
	logic [PTR_W-1:0]  wp_q, rp_q, wp_inc, rp_inc, wp_a, rp_a, rp_n;
	logic [PTR_W:0]    cnt;
	logic [CNT_W-1:0]  cnt_ext;
	logic              full, do_push, pop_ok;

	// Push first, then serve the pop against the updated contents.
	always_comb begin
		wp_inc  = (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
		rp_inc  = (rp_q == LAST_PTR) ? '0 : rp_q + PTR_W'(1);
		full    = (wp_inc == rp_q);
		do_push = push.valid && !full;
		wp_a    = do_push ? wp_inc : wp_q;
		pop_ok  = pop_req && (wp_a != rp_q);
		rp_a    = pop_ok ? rp_inc : rp_q;
		rp_n    = adv ? rp_a : rp_q;
		cnt     = (wp_a >= rp_a) ? ({1'b0, wp_a} - {1'b0, rp_a})
			: ({1'b0, wp_a} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, rp_a});
		cnt_ext = CNT_W'(cnt);
		status.pop_valid  = pop_ok;
		// An empty FIFO can only be popped when the byte arrives this tick.
		status.pop_byte   = !pop_ok ? '0 : ((rp_q == wp_q) ? push.data : head_q);
		status.fill_count = cnt_ext[FILL_W-1:0];
		status.overflow   = push.valid && full;
	end

	// Storage write, with the head entry re-read every cycle at the next read pointer.
	always_ff @(posedge clk) begin
		if (adv && do_push) begin
			mem[wp_q] <= push.data;
		end
		if (adv && do_push && (wp_q == rp_n)) begin
			head_q <= push.data;
		end else begin
			head_q <= mem[rp_n];
		end
	end

	// Pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (adv) begin
			wp_q <= wp_a;
			rp_q <= rp_a;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the serial receiver with receive FIFO.
`timescale 1ns / 1ps

module testbench;
	import urxf_pkg::*;

	localparam int unsigned DEPTH = 64;

	// One sampled line tick as offered to the receiver.
	typedef struct {
		logic level;
		logic pop;
	} line_tick_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic                line_level = 1'b1;
	logic                pop_req    = 1'b0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic                pop_valid;
	logic [DATA_W-1:0]   pop_byte;
	logic [FILL_W-1:0]   fill_count;
	logic                overflow;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data   = '0;

	uart_receiver_with_fifo #(.FIFO_DEPTH(DEPTH)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.line_level (line_level),
		.pop_req    (pop_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pop_valid  (pop_valid),
		.pop_byte   (pop_byte),
		.fill_count (fill_count),
		.overflow   (overflow),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Line ticks waiting to be driven, and the FIFO status each accepted tick should produce.
	line_tick_t   tick_q[$];
	fifo_status_t status_q[$];

	int  n_queued  = 0;
	int  n_checked = 0;
	int  n_cfg     = 0;
	int  n_faults  = 0;
	int  n_pops    = 0;
	int  n_drops   = 0;
	int  peak_fill = 0;
	bit  in_fire   = 1'b0;
	bit  out_fire  = 1'b0;
	int  in_gap    = 0;
	bit  in_calm   = 1'b0;
	int  out_wait  = 0;
	bit  out_calm  = 1'b0;
	bit  hold_armed = 1'b0;
	bit  hold_done  = 1'b0;
	int  hold_left  = 0;

	// Receiver and FIFO state as this testbench expects it.
	logic [PERIOD_W-1:0] rx_period = PERIOD_RESET;
	phase_t              rx_phase  = PH_IDLE;
	logic [PERIOD_W-1:0] rx_ticks  = '0;
	logic [BIT_W-1:0]    rx_bit    = '0;
	logic [DATA_W-1:0]   rx_shift  = '0;
	logic [DATA_W-1:0]   rx_store [DEPTH];
	logic [FILL_W-1:0]   rx_wr     = '0;
	logic [FILL_W-1:0]   rx_rd     = '0;

	// Advances the bit timer and reports whether the phase target has been reached.
	function automatic bit timer_reached(input logic [PERIOD_W-1:0] target);
		rx_ticks = rx_ticks + 1'b1;
		if (rx_ticks >= target) begin
			rx_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Steps the receiver by one line tick and returns the FIFO status it should report.
	function automatic fifo_status_t rx_sample(input logic level, input logic pop);
		fifo_status_t res;
		logic [FILL_W-1:0] wr_after;
		res = '0;
		case (rx_phase)
			PH_IDLE: begin
				if (!level) begin
					rx_phase = PH_START;
					rx_ticks = '0;
				end
			end
			PH_START: begin
				if (timer_reached(rx_period >> 1)) begin
					if (level) begin
						rx_phase = PH_IDLE;
					end else begin
						rx_phase = PH_DATA;
						rx_bit   = '0;
						rx_shift = '0;
					end
				end
			end
			PH_DATA: begin
				if (timer_reached(rx_period)) begin
					if (level)
						rx_shift[rx_bit] = 1'b1;
					if (rx_bit == LAST_BIT) begin
						rx_bit   = '0;
						rx_phase = PH_STOP;
					end else begin
						rx_bit = rx_bit + 1'b1;
					end
				end
			end
			default: begin
				// Stop bit: its level is ignored, the byte goes to the FIFO unless full.
				if (timer_reached(rx_period)) begin
					wr_after = rx_wr + 1'b1;
					if (wr_after != rx_rd) begin
						rx_store[rx_wr] = rx_shift;
						rx_wr = wr_after;
					end else begin
						res.overflow = 1'b1;
					end
					rx_phase = PH_IDLE;
				end
			end
		endcase
		// A byte pushed this tick may be popped in the same tick.
		if (pop && rx_wr != rx_rd) begin
			res.pop_valid = 1'b1;
			res.pop_byte  = rx_store[rx_rd];
			rx_rd = rx_rd + 1'b1;
		end
		res.fill_count = rx_wr - rx_rd;
		return res;
	endfunction

	function automatic void report_fault(input string msg);
		n_faults++;
		if (n_faults <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Monitor: checks each result transfer, tracks register writes and predicts each input transfer.
	always @(posedge clk) begin : monitor
		fifo_status_t seen;
		fifo_status_t want;
		in_fire  = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (out_fire) begin
			seen = {pop_valid, pop_byte, fill_count, overflow};
			if (status_q.size() == 0) begin
				report_fault($sformatf("%0t: result with nothing expected: valid %0b byte %02h fill %0d overflow %0b",
					$realtime, seen.pop_valid, seen.pop_byte, seen.fill_count, seen.overflow));
			end else begin
				want = status_q.pop_front();
				n_checked++;
				n_pops  += want.pop_valid;
				n_drops += want.overflow;
				if (want.fill_count > peak_fill)
					peak_fill = want.fill_count;
				if (seen.pop_valid !== want.pop_valid || seen.pop_byte !== want.pop_byte ||
						seen.fill_count !== want.fill_count || seen.overflow !== want.overflow)
					report_fault($sformatf({"%0t: result %0d mismatch: expected valid %0b byte %02h ",
						"fill %0d overflow %0b, got valid %0b byte %02h fill %0d overflow %0b"},
						$realtime, n_checked, want.pop_valid, want.pop_byte, want.fill_count,
						want.overflow, seen.pop_valid, seen.pop_byte, seen.fill_count, seen.overflow));
			end
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			rx_period = cfg_data;
			n_cfg++;
		end
		if (in_fire)
			status_q.push_back(rx_sample(line_level, pop_req));
	end

	// Driver: offers the next line tick after a random wait, holding it until transferred.
	always @(negedge clk) begin : driver
		line_tick_t pending;
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				pending = tick_q.pop_front();
				line_level <= pending.level;
				pop_req    <= pending.pop;
				in_valid   <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 17);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long hold-off on the result side, counted here so that the pipeline fills up.
	always @(posedge clk) begin : hold_off
		if (hold_armed && !hold_done) begin
			hold_left = 120;
			hold_done = 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	// Result side: stalls for a random number of cycles after each transfer.
	always @(negedge clk) begin : receiver
		if (out_fire) begin
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
			out_wait = out_calm ? 0 : $urandom_range(0, 17);
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic queue_tick(input logic level, input logic pop);
		line_tick_t t;
		t.level = level;
		t.pop   = pop;
		tick_q.push_back(t);
		n_queued++;
	endtask

	// One 8N1 frame, LSB first, at the given bit period, with the start bit cut short to the half-bit check.
	task automatic queue_frame(input logic [7:0] data, input int unsigned period, input int pct,
			input logic stop_level);
		queue_tick(1'b0, chance(pct));
		repeat (period >> 1) queue_tick(1'b0, chance(pct));
		for (int b = 0; b < 8; b++)
			repeat (period) queue_tick(data[b], chance(pct));
		repeat (period) queue_tick(stop_level, chance(pct));
	endtask

	// A random stretch of traffic: mostly clean frames, some broken ones and line noise.
	task automatic queue_stretch(input int unsigned period, input int pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		repeat ($urandom_range(0, 3)) queue_tick(1'b1, chance(pct));
		if (roll < 75) begin
			queue_frame(8'($urandom), period, pct, 1'b1);
		end else if (roll < 83) begin
			// Framing error: the stop bit is low.
			queue_frame(8'($urandom), period, pct, 1'b0);
		end else if (roll < 92) begin
			// A start bit that is high again by the half-bit check.
			queue_tick(1'b0, chance(pct));
			repeat ((period >> 1) - 1) queue_tick(1'b0, chance(pct));
			queue_tick(1'b1, chance(pct));
		end else begin
			repeat ($urandom_range(1, 8)) queue_tick(1'($urandom), chance(pct));
		end
	endtask

	// Waits until every queued tick has produced its checked result.
	task automatic settle();
		while (n_checked != n_queued) @(negedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		int target;
		target = n_cfg + 1;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		while (n_cfg != target) @(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int base;
		int pct;
		logic [PERIOD_W-1:0] period;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A pop on an empty FIFO, then a start bit at the reset bit period.
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b1, 1'b0);
		repeat (4) queue_tick(1'b0, 1'b0);
		settle();
		// Lowering the period mid start check fires the check on the next tick.
		write_period(16'd4);
		queue_tick(1'b0, 1'b0);
		repeat (32) queue_tick(1'b1, 1'b0);
		// All-ones byte pushed and popped on the same tick.
		repeat (3) queue_tick(1'b1, 1'b0);
		queue_tick(1'b1, 1'b1);
		// Start glitch, then an all-zeros byte read back and a pop on the emptied FIFO.
		repeat (2) queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_frame(8'h00, 4, 0, 1'b1);
		repeat (2) queue_tick(1'b1, 1'b1);
		settle();

		// Largest bit period: the start check runs on without firing.
		write_period(16'hFFFF);
		queue_tick(1'b0, 1'b0);
		repeat (10) queue_tick(1'($urandom), 1'($urandom));
		settle();
		write_period(16'd4);

		// Random traffic over several bit periods, pausing for all results between them.
		for (int s = 0; s < 5; s++) begin
			period = (s == 0) ? 16'd4 : (s == 1) ? 16'd5 : 16'($urandom_range(6, 24));
			pct = $urandom_range(5, 40);
			settle();
			write_period(period);
			base = n_queued;
			while (n_queued < base + 130)
				queue_stretch(period, pct);
			if (s == 2)
				hold_armed = 1'b1;
		end

		// A few bytes held in the FIFO with no pops, then drained past empty.
		settle();
		write_period(16'd4);
		repeat (4) queue_tick(1'b1, 1'b0);
		repeat (3) queue_frame(8'($urandom), 4, 0, 1'b1);
		repeat (6) queue_tick(1'b1, 1'b1);
		settle();

		repeat (8) @(negedge clk);
		if (status_q.size() != 0)
			report_fault($sformatf("%0d expected results never arrived", status_q.size()));
		$display("Ran %0d line ticks across %0d bit period settings, from 4 to 65535 ticks per bit.",
			n_queued, n_cfg + 1);
		$display("%0d bytes were read back, %0d dropped on a full FIFO, peak fill %0d.",
			n_pops, n_drops, peak_fill);
		if (n_faults == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/urxf_pkg.sv
src/urxf_deser.sv
src/urxf_fifo.sv
src/uart_receiver_with_fifo.sv
tb/testbench.sv
